FILE: sv/tsp_pkg.sv
// Shared types and constants for the trapezoid stepper profile block.
package tsp_pkg;

  // Command action codes
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_DELAY  = 2'd0,
    CFG_CRUISE_DELAY = 2'd1,
    CFG_ACCEL_STEP   = 2'd2,
    CFG_RAMP_LENGTH  = 2'd3
  } cfg_index_t;

  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] START_DELAY_RST  = 8'd200;
  localparam logic [7:0] CRUISE_DELAY_RST = 8'd100;
  localparam logic [7:0] ACCEL_STEP_RST   = 8'd10;
  localparam logic [5:0] RAMP_LENGTH_RST  = 6'd10;

  // Half-step coil patterns: bit0 A1, bit1 A2, bit2 B1, bit3 B2
  localparam logic [3:0] COIL_TABLE [8] = '{
    4'd4, 4'd6, 4'd2, 4'd10, 4'd8, 4'd9, 4'd1, 4'd5
  };

  typedef struct packed {
    logic [7:0] start_delay;
    logic [7:0] cruise_delay;
    logic [7:0] accel_step;
    logic [5:0] ramp_length;
  } cfg_t;

  typedef struct packed {
    logic       step_valid;
    logic       step_dir;
    logic [7:0] step_delay;
    logic [3:0] coil_drive;
    logic       move_last;
    logic       busy_res;
  } res_t;

endpackage

FILE: sv/tsp_cmd_if.sv
// Command channel: action and signed step count with valid/ready.
interface tsp_cmd_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  action_t           action;
  logic signed [7:0] step_count;

  modport source (output valid, output action, output step_count, input ready);
  modport sink   (input valid, input action, input step_count, output ready);
endinterface

FILE: sv/tsp_res_if.sv
// Result channel: one step result per command with valid/ready.
interface tsp_res_if;
  logic       valid;
  logic       ready;
  logic       step_valid;
  logic       step_dir;
  logic [7:0] step_delay;
  logic [3:0] coil_drive;
  logic       move_last;
  logic       busy_res;

  modport source (output valid, output step_valid, output step_dir, output step_delay,
                  output coil_drive, output move_last, output busy_res, input ready);
  modport sink   (input valid, input step_valid, input step_dir, input step_delay,
                  input coil_drive, input move_last, input busy_res, output ready);
endinterface

FILE: sv/tsp_delay.sv
// Trapezoid delay calculation for one step of a move.
module tsp_delay (
  input  tsp_pkg::cfg_t cfg,
  input  logic [6:0]    step_idx,
  input  logic [6:0]    step_total,
  output logic [7:0]    delay
);
  import tsp_pkg::*;

  logic [6:0]         half;
  logic [6:0]         ramp;
  logic               long_move;
  logic [7:0]         base;
  logic [6:0]         k;
  logic               add_k;
  logic [14:0]        prod;
  logic signed [16:0] sum;

  assign half      = step_total >> 1;
  assign ramp      = {1'b0, cfg.ramp_length};
  assign long_move = step_total > {cfg.ramp_length, 1'b0};

  // Pick the ramp base and the step distance along the ramp
  always_comb begin
    base  = cfg.start_delay;
    k     = step_idx;
    add_k = 1'b0;
    if (long_move) begin
      if (step_idx < ramp) begin
        base = cfg.start_delay;
        k    = step_idx;
      end else if (step_idx < step_total - ramp) begin
        base = cfg.cruise_delay;
        k    = '0;
      end else begin
        base  = cfg.cruise_delay;
        k     = step_idx - (step_total - ramp);
        add_k = 1'b1;
      end
    end else if (step_idx > half) begin
      // Short move, way back up: mirror around the midpoint step
      k = {half[5:0], 1'b1} - step_idx;
    end
  end

  assign prod = 15'(k) * 15'(cfg.accel_step);
  assign sum  = add_k ? $signed({9'd0, base}) + $signed({2'd0, prod})
                      : $signed({9'd0, base}) - $signed({2'd0, prod});

  // Saturate to 1..255
  always_comb begin
    if (sum < 17'sd1) begin
      delay = 8'd1;
    end else if (sum > 17'sd255) begin
      delay = 8'd255;
    end else begin
      delay = sum[7:0];
    end
  end
endmodule

FILE: sv/tsp_out_reg.sv
// Result register between the step logic and the result channel.
module tsp_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tsp_pkg::res_t  data,
  output logic           free,
  tsp_res_if.source      res
);
  import tsp_pkg::*;

  logic valid;
  res_t held;

  assign free = !valid || res.ready;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= data;
    end
  end

  assign res.valid      = valid;
  assign res.step_valid = held.step_valid;
  assign res.step_dir   = held.step_dir;
  assign res.step_delay = held.step_delay;
  assign res.coil_drive = held.coil_drive;
  assign res.move_last  = held.move_last;
  assign res.busy_res   = held.busy_res;
endmodule

FILE: sv/trapezoid_stepper_profile.sv
// Top level of the trapezoidal stepper motion profile with half-step coil sequencing.
//
// Channels: cmd takes one command per transaction (start a move with a signed
// step count, request the next step, or release the coils). res returns exactly
// one result per command: step flag, direction, timer delay, coil pattern,
// last-step flag and busy flag. Registers start_delay, cruise_delay, accel_step
// and ramp_length are written through cfg_write/cfg_index/cfg_data; the user
// must do so only while idle; the block does not enforce it. A result is in the
// result register in the cycle after its command. Throughput: one command per cycle
// while the result register is not stalled; the step delay, phase update and coil
// lookup are all done in the accepting cycle, and the result register sets the rate.
// Reset: configuration returns to 200/100/10/10, no move is active, the phase
// index is zero and all coils are off.
// Stall: while a result waits in the result register and res.ready is low,
// cmd.ready drops and the state holds; no result is lost or repeated.
module trapezoid_stepper_profile #(
  parameter int unsigned PHASE_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  tsp_pkg::cfg_index_t         cfg_index,
  input  logic [tsp_pkg::CfgDataW-1:0] cfg_data,
  tsp_cmd_if.sink                     cmd,
  tsp_res_if.source                   res
);
  import tsp_pkg::*;

  localparam int unsigned PW = $clog2(PHASE_COUNT);

  cfg_t          cfg;
  logic          move_dir, move_dir_next;
  logic [PW-1:0] phase_index, phase_index_next;
  logic [6:0]    steps_done, steps_done_next;
  logic [6:0]    steps_total, steps_total_next;
  logic [3:0]    coil_state, coil_state_next;
  logic [3:0]    phase_coil [2**PW];
  logic [7:0]    step_delay;
  logic [6:0]    count_mag;
  logic          free;
  logic          accept;
  res_t          result;

  // Coil pattern for each phase index, spread over the half-step table
  for (genvar p = 0; p < 2**PW; p++) begin : g_phase_coil
    if (p < PHASE_COUNT) begin : g_used
      assign phase_coil[p] = COIL_TABLE[(p * 8 / PHASE_COUNT) % 8];
    end else begin : g_unused
      assign phase_coil[p] = 4'd0;
    end
  end

  tsp_delay u_delay (
    .cfg        (cfg),
    .step_idx   (steps_done),
    .step_total (steps_total),
    .delay      (step_delay)
  );

  assign accept    = cmd.valid && free;
  assign cmd.ready = free;

  // Magnitude of the step count, with the most negative code clamped
  assign count_mag = (cmd.step_count == 8'sh80) ? 7'd127
                   : (cmd.step_count[7] ? 7'(-cmd.step_count) : 7'(cmd.step_count));

  // Next state and result for the command at the port
  always_comb begin
    move_dir_next     = move_dir;
    phase_index_next  = phase_index;
    steps_done_next   = steps_done;
    steps_total_next  = steps_total;
    coil_state_next   = coil_state;
    result.step_valid = 1'b0;
    result.step_delay = 8'd0;
    result.move_last  = 1'b0;
    unique case (cmd.action)
      ACT_START: begin
        move_dir_next    = (cmd.step_count > 8'sd0);
        steps_total_next = count_mag;
        steps_done_next  = 7'd0;
      end
      ACT_STEP: begin
        if (steps_done < steps_total) begin
          if (move_dir) begin
            phase_index_next = (phase_index == PW'(PHASE_COUNT - 1)) ? '0 : phase_index + 1'b1;
          end else begin
            phase_index_next = (phase_index == '0) ? PW'(PHASE_COUNT - 1) : phase_index - 1'b1;
          end
          coil_state_next   = phase_coil[phase_index_next];
          steps_done_next   = steps_done + 7'd1;
          result.step_valid = 1'b1;
          result.step_delay = step_delay;
          result.move_last  = (steps_done_next >= steps_total);
        end
      end
      ACT_RELEASE: begin
        coil_state_next = 4'd0;
      end
      default: begin
      end
    endcase
    result.step_dir   = move_dir_next;
    result.coil_drive = coil_state_next;
    result.busy_res   = (steps_done_next < steps_total_next);
  end

  // Advance the move state on each accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      move_dir    <= 1'b0;
      phase_index <= '0;
      steps_done  <= 7'd0;
      steps_total <= 7'd0;
      coil_state  <= 4'd0;
    end else if (accept) begin
      move_dir    <= move_dir_next;
      phase_index <= phase_index_next;
      steps_done  <= steps_done_next;
      steps_total <= steps_total_next;
      coil_state  <= coil_state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay  <= START_DELAY_RST;
      cfg.cruise_delay <= CRUISE_DELAY_RST;
      cfg.accel_step   <= ACCEL_STEP_RST;
      cfg.ramp_length  <= RAMP_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_START_DELAY:  cfg.start_delay  <= cfg_data;
        CFG_CRUISE_DELAY: cfg.cruise_delay <= cfg_data;
        CFG_ACCEL_STEP:   cfg.accel_step   <= cfg_data;
        CFG_RAMP_LENGTH:  cfg.ramp_length  <= cfg_data[5:0];
      endcase
    end
  end

  tsp_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .data (result),
    .free (free),
    .res  (res)
  );
endmodule
